@@ hdl/orbit_camera_position_macros.svh @@
// ----------------------------------------------------------------------------
// Orbit camera position: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORBIT_CAMERA_POSITION_MACROS_SVH
`define ORBIT_CAMERA_POSITION_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define OCP_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("orbit camera check failed");

// Next-cycle implication, checked outside reset.
`define OCP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("orbit camera check failed");

`else

`define OCP_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define OCP_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

@@ hdl/ocp_pkg.sv @@
// ----------------------------------------------------------------------------
// Orbit camera position: shared package
// Field widths, command and register codes, word types and sequencer codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ocp_pkg;

  localparam int ANGLE_BITS          = 16;
  localparam int DIST_BITS           = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int CFG_DATA_BITS       = 24;
  localparam int ACTION_BITS         = 3;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic signed [DIST_BITS-1:0] INIT_DIST_RESET = DIST_BITS'(5120);

  // Polynomial coefficients of the quarter-wave sine, Q16.
  localparam int SIN_FRAC_BITS = 16;
  localparam logic [16:0] SIN_A1 = 17'd102944;
  localparam logic [16:0] SIN_A3 = 17'd42047;
  localparam logic [16:0] SIN_A5 = 17'd4640;
  localparam logic [16:0] SIN_MAX = 17'd32767;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_SET_ANGLES = 3'd0,
    ACT_ADD_ANGLES = 3'd1,
    ACT_SET_DIST   = 3'd2,
    ACT_ADD_DIST   = 3'd3,
    ACT_RESTORE    = 3'd4
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INIT_AZIMUTH   = 2'd0,
    REG_INIT_ELEVATION = 2'd1,
    REG_INIT_DISTANCE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0]       action;
    logic [ANGLE_BITS-1:0]        azimuth_value;
    logic [ANGLE_BITS-1:0]        elevation_value;
    logic signed [DIST_BITS-1:0]  distance_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DIST_BITS-1:0]  pos_x;
    logic signed [DIST_BITS-1:0]  pos_y;
    logic signed [DIST_BITS-1:0]  pos_z;
    logic                         up_flipped;
  } res_t;

  // Camera state after a command, handed from the front to the back.
  typedef struct packed {
    logic [ANGLE_BITS-1:0]        azimuth;
    logic [ANGLE_BITS-1:0]        elevation;
    logic signed [DIST_BITS-1:0]  distance;
    logic                         up_flipped;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_POST
  } back_state_t;

  // Steps of the shared multiplier.
  typedef enum logic [3:0] {
    OP_USQ,
    OP_T5,
    OP_T3,
    OP_T1,
    OP_CX,
    OP_CZ,
    OP_PX,
    OP_PY,
    OP_PZ
  } op_t;

endpackage

`default_nettype wire

@@ hdl/orbit_camera_position.sv @@
// ----------------------------------------------------------------------------
// Orbit camera position: top level
// Turns camera commands into the position on the orbit sphere.
// ----------------------------------------------------------------------------
// Commands enter as words on push/full and results leave as words on
// empty/pop, both behaving as a queue. A command is taken when push is high
// and full is low; the oldest result sits on result while empty is low and
// is removed when pop is high. Every command gives exactly one result word.
// The three initial-value registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block
// is idle, which the block does not enforce. An unused index is ignored.
// The back end fetches a job from the queue and then runs 21 products
// (four sine polynomials of four steps, two angle products, three
// positions) through one multiplier, each in a multiply and a post state.
// The front applies commands at once into a two-word job queue, so up to
// two commands are taken while the back end is busy with a job.
// Reset clears both queues, restores the registers to azimuth 0,
// elevation 0 and distance 20.0, and loads those into the camera state.
// While a result waits to be popped the back end finishes its current
// job and then holds; the job queue fills and full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orbit_camera_position #(
  parameter int SINE_TABLE_BITS = ocp_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [ocp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [ocp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire ocp_pkg::cmd_t                         cmd,
  output logic                                       empty,
  input  wire logic                                  pop,
  output ocp_pkg::res_t                              result
);

  logic          job_push;
  ocp_pkg::job_t job_front;
  logic          q_full;
  logic          q_empty;
  logic          job_pop;
  ocp_pkg::job_t job_back;

  assign full = q_full;

  ocp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .cmd       (cmd),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job_front)
  );

  ocp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job_front),
    .full    (q_full),
    .rd      (job_pop),
    .rd_data (job_back),
    .empty   (q_empty)
  );

  ocp_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (q_empty),
    .job_in    (job_back),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ hdl/ocp_front.sv @@
// ----------------------------------------------------------------------------
// Orbit camera position: command front end
// Holds the configuration and the camera state, applies each command and
// passes the resulting state on to the job queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ocp_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [ocp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [ocp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  wire logic                                  push,
  input  wire ocp_pkg::cmd_t                         cmd,
  input  wire logic                                  q_full,
  output logic                                       job_push,
  output ocp_pkg::job_t                              job
);

  localparam int AB = ocp_pkg::ANGLE_BITS;
  localparam int DB = ocp_pkg::DIST_BITS;
  localparam logic [AB-1:0] QUARTER       = AB'(1) << (AB - 2);
  localparam logic [AB-1:0] THREE_QUARTER = AB'(3) << (AB - 2);

  logic [AB-1:0]        init_az;
  logic [AB-1:0]        init_el;
  logic signed [DB-1:0] init_dist;
  logic [AB-1:0]        az;
  logic [AB-1:0]        el;
  logic signed [DB-1:0] distance;
  logic [AB-1:0]        az_next;
  logic [AB-1:0]        el_next;
  logic signed [DB-1:0] dist_next;
  logic signed [DB:0]   dist_sum;
  logic signed [DB-1:0] dist_sat;

  assign job_push = push && !q_full;

  // One extra bit catches overflow of the distance add.
  assign dist_sum = {distance[DB-1], distance}
                  + {cmd.distance_value[DB-1], cmd.distance_value};

  always_comb begin
    if (dist_sum[DB] != dist_sum[DB-1]) begin
      dist_sat = dist_sum[DB] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
    end else begin
      dist_sat = dist_sum[DB-1:0];
    end
  end

  always_comb begin
    az_next   = az;
    el_next   = el;
    dist_next = distance;
    unique case (cmd.action)
      ocp_pkg::ACT_SET_ANGLES: begin
        az_next = cmd.azimuth_value;
        el_next = cmd.elevation_value;
      end
      ocp_pkg::ACT_ADD_ANGLES: begin
        az_next = az + cmd.azimuth_value;
        el_next = el + cmd.elevation_value;
      end
      ocp_pkg::ACT_SET_DIST: begin
        dist_next = cmd.distance_value;
      end
      ocp_pkg::ACT_ADD_DIST: begin
        dist_next = dist_sat;
      end
      ocp_pkg::ACT_RESTORE: begin
        az_next   = init_az;
        el_next   = init_el;
        dist_next = init_dist;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job.azimuth    = az_next;
    job.elevation  = el_next;
    job.distance   = dist_next;
    job.up_flipped = (el_next > QUARTER) && (el_next <= THREE_QUARTER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_az   <= '0;
      init_el   <= '0;
      init_dist <= ocp_pkg::INIT_DIST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ocp_pkg::REG_INIT_AZIMUTH:   init_az   <= cfg_data[AB-1:0];
        ocp_pkg::REG_INIT_ELEVATION: init_el   <= cfg_data[AB-1:0];
        ocp_pkg::REG_INIT_DISTANCE:  init_dist <= signed'(cfg_data[DB-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      az       <= '0;
      el       <= '0;
      distance <= ocp_pkg::INIT_DIST_RESET;
    end else if (job_push) begin
      az       <= az_next;
      el       <= el_next;
      distance <= dist_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ocp_queue.sv @@
// ----------------------------------------------------------------------------
// Orbit camera position: job queue
// Short first-in first-out store that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "orbit_camera_position_macros.svh"

module ocp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire ocp_pkg::job_t  wr_data,
  output logic                full,
  input  wire logic           rd,
  output ocp_pkg::job_t       rd_data,
  output logic                empty
);

  localparam int DEPTH = ocp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ocp_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // The fill level never passes the depth, and the front never offers a
  // word while the queue is full.
  `OCP_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, (count <= CNT_W'(DEPTH)))
  `OCP_ASSERT_IMPL(a_no_write_when_full, clk, rst, wr, !full)

endmodule

`default_nettype wire

@@ hdl/ocp_back.sv @@
// ----------------------------------------------------------------------------
// Orbit camera position: trigonometry back end
// Evaluates the four sines and cosines and the three position products on
// one shared multiplier in multiply and post states; holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "orbit_camera_position_macros.svh"

module ocp_back #(
  parameter int SINE_TABLE_BITS = ocp_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_empty,
  input  wire ocp_pkg::job_t  job_in,
  output logic                job_pop,
  output logic                empty,
  input  wire logic           pop,
  output ocp_pkg::res_t       result
);

  localparam int AB      = ocp_pkg::ANGLE_BITS;
  localparam int DB      = ocp_pkg::DIST_BITS;
  localparam int STB     = SINE_TABLE_BITS;
  localparam int QB      = STB - 2;
  localparam int UF      = ocp_pkg::SIN_FRAC_BITS;
  localparam int U_W     = UF + 1;
  localparam int MUL_A_W = DB;
  localparam int MUL_B_W = U_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SC_W    = PROD_W - 15;

  localparam logic [STB-1:0]      QTR_IDX = STB'(1) << QB;
  localparam logic [QB:0]         N_K     = (QB + 1)'(1) << QB;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << 14;

  ocp_pkg::back_state_t state;
  ocp_pkg::back_state_t state_next;
  ocp_pkg::op_t         op;
  logic [1:0]           ang;
  logic                 out_load;
  logic                 out_valid;
  logic                 out_free;

  ocp_pkg::job_t        job;
  logic signed [PROD_W-1:0]  prod;
  logic [U_W-1:0]            u2;
  logic [U_W-1:0]            t;
  logic signed [15:0]        sv [4];
  logic signed [U_W-1:0]     cx;
  logic signed [U_W-1:0]     cz;
  logic signed [DB-1:0]      px;
  logic signed [DB-1:0]      py;

  logic [AB-1:0]             phase;
  logic [STB-1:0]            idx;
  logic [QB-1:0]             frac;
  logic [QB:0]               k;
  logic [U_W-1:0]            u;
  logic                      neg;
  logic signed [MUL_A_W-1:0] a_op;
  logic signed [MUL_B_W-1:0] b_op;
  logic signed [PROD_W-1:0]  mul_res;
  logic [U_W-1:0]            sin_p;
  logic signed [15:0]        sin_mag;
  logic signed [15:0]        sin_val;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [SC_W-1:0]    scaled;
  logic signed [DB-1:0]      pos_sat;

  // Angle slot: bit 1 picks elevation, bit 0 picks cosine (a quarter turn on).
  always_comb begin
    phase = ang[1] ? job.elevation : job.azimuth;
    idx   = phase[AB-1 -: STB] + (ang[0] ? QTR_IDX : '0);
    frac  = idx[QB-1:0];
    k     = idx[QB] ? (N_K - (QB + 1)'(frac)) : (QB + 1)'(frac);
    u     = U_W'(k) << (UF - QB);
    neg   = idx[STB-1];
  end

  always_comb begin
    case (op)
      ocp_pkg::OP_USQ: begin
        a_op = signed'(MUL_A_W'(u));
        b_op = signed'({1'b0, u});
      end
      ocp_pkg::OP_T5: begin
        a_op = signed'(MUL_A_W'(ocp_pkg::SIN_A5));
        b_op = signed'({1'b0, u2});
      end
      ocp_pkg::OP_T3: begin
        a_op = signed'(MUL_A_W'(ocp_pkg::SIN_A3 - t));
        b_op = signed'({1'b0, u2});
      end
      ocp_pkg::OP_T1: begin
        a_op = signed'(MUL_A_W'(ocp_pkg::SIN_A1 - t));
        b_op = signed'({1'b0, u});
      end
      ocp_pkg::OP_CX: begin
        a_op = MUL_A_W'(sv[1]);
        b_op = MUL_B_W'(sv[3]);
      end
      ocp_pkg::OP_CZ: begin
        a_op = MUL_A_W'(sv[0]);
        b_op = MUL_B_W'(sv[3]);
      end
      ocp_pkg::OP_PX: begin
        a_op = job.distance;
        b_op = MUL_B_W'(cx);
      end
      ocp_pkg::OP_PY: begin
        a_op = job.distance;
        b_op = MUL_B_W'(sv[2]);
      end
      ocp_pkg::OP_PZ: begin
        a_op = job.distance;
        b_op = MUL_B_W'(cz);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign mul_res = a_op * b_op;

  // Last polynomial step: drop seventeen bits, clip to full scale, apply sign.
  always_comb begin
    sin_p   = prod[UF+17:17];
    sin_mag = (sin_p > ocp_pkg::SIN_MAX) ? 16'sd32767 : signed'(sin_p[15:0]);
    sin_val = neg ? -sin_mag : sin_mag;
  end

  // Round half up by fifteen bits, then clip to the distance range.
  always_comb begin
    rnd    = prod + HALF_LSB;
    scaled = rnd[PROD_W-1:15];
    if ((&scaled[SC_W-1:DB-1]) || !(|scaled[SC_W-1:DB-1])) begin
      pos_sat = scaled[DB-1:0];
    end else begin
      pos_sat = scaled[SC_W-1] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
    end
  end

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ocp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ocp_pkg::BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = ocp_pkg::BK_MUL;
        end
      end
      ocp_pkg::BK_MUL: begin
        state_next = ocp_pkg::BK_POST;
      end
      ocp_pkg::BK_POST: begin
        if (op == ocp_pkg::OP_PZ) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ocp_pkg::BK_IDLE;
          end
        end else begin
          state_next = ocp_pkg::BK_MUL;
        end
      end
      default: begin
        state_next = ocp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op  <= ocp_pkg::OP_USQ;
      ang <= '0;
    end else if (job_pop) begin
      job <= job_in;
      op  <= ocp_pkg::OP_USQ;
      ang <= '0;
    end else if (state == ocp_pkg::BK_MUL) begin
      prod <= mul_res;
    end else if (state == ocp_pkg::BK_POST) begin
      case (op)
        ocp_pkg::OP_USQ: begin
          u2 <= prod[UF+16:UF];
          op <= ocp_pkg::OP_T5;
        end
        ocp_pkg::OP_T5: begin
          t  <= prod[UF+16:UF];
          op <= ocp_pkg::OP_T3;
        end
        ocp_pkg::OP_T3: begin
          t  <= prod[UF+16:UF];
          op <= ocp_pkg::OP_T1;
        end
        ocp_pkg::OP_T1: begin
          sv[ang] <= sin_val;
          if (ang == 2'd3) begin
            op <= ocp_pkg::OP_CX;
          end else begin
            ang <= ang + 2'd1;
            op  <= ocp_pkg::OP_USQ;
          end
        end
        ocp_pkg::OP_CX: begin
          cx <= rnd[U_W+14:15];
          op <= ocp_pkg::OP_CZ;
        end
        ocp_pkg::OP_CZ: begin
          cz <= rnd[U_W+14:15];
          op <= ocp_pkg::OP_PX;
        end
        ocp_pkg::OP_PX: begin
          px <= pos_sat;
          op <= ocp_pkg::OP_PY;
        end
        ocp_pkg::OP_PY: begin
          py <= pos_sat;
          op <= ocp_pkg::OP_PZ;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.pos_x      <= px;
      result.pos_y      <= py;
      result.pos_z      <= pos_sat;
      result.up_flipped <= job.up_flipped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // A waiting result is never overwritten, and every job starts its
  // sequence from the azimuth sine.
  `OCP_ASSERT_IMPL(a_no_overwrite, clk, rst, out_load, (!out_valid || pop))
  `OCP_ASSERT_NEXT(a_job_start, clk, rst, job_pop, ((op == ocp_pkg::OP_USQ) && (ang == 2'd0)))

endmodule

`default_nettype wire
